// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RLEID_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition in one cycle implies a condition in the same cycle
`define RLEID_ASSERT_IMPLIES(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define RLEID_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/rleid_pkg.sv =====
// types and constants of the run-length image decoder
package rleid_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ORIGIN_X    = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y    = 3'd1;
   localparam csr_index_type CSR_IMAGE_W     = 3'd2;
   localparam csr_index_type CSR_IMAGE_H     = 3'd3;
   localparam csr_index_type CSR_SEE_THROUGH = 3'd4;

   localparam logic [7:0] MARKER_BITS = 8'hC0;
   localparam logic [7:0] COUNT_MASK  = 8'h3F;

   typedef struct packed {
      logic signed [10:0] origin_x;
      logic signed [10:0] origin_y;
      logic [9:0]         image_width;
      logic [9:0]         image_height;
      logic [7:0]         see_through;
   } cfg_type;

   typedef struct packed {
      logic       first_done;
      logic [9:0] cur_x;
      logic [9:0] cur_y;
      logic       visible;
      logic [8:0] pix_x;
      logic [7:0] pix_y;
      logic       next_done;
      logic [9:0] next_x;
      logic [9:0] next_y;
   } step_type;

endpackage

// ===== hw/rtl/rleid_channels_if.sv =====
// valid/ready channel interfaces for compressed bytes and pixel writes
interface rleid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_start;
   logic       final_byte;

   modport source (output valid, data_byte, stream_start, final_byte, input ready);
   modport sink (input valid, data_byte, stream_start, final_byte, output ready);
endinterface

interface rleid_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] pixel_x;
   logic [7:0] pixel_y;
   logic [7:0] pixel_colour;
   logic       run_last;

   modport source (output valid, pixel_x, pixel_y, pixel_colour, run_last, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_colour, run_last, output ready);
endinterface

// ===== hw/rtl/rleid_pixel_step.sv =====
// one pixel step: cursor settle, screen position, clip test and advance
module rleid_pixel_step #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 200
) (
   input  rleid_pkg::cfg_type  cfg,
   input  logic [9:0]          cursor_x,
   input  logic [9:0]          cursor_y,
   input  logic [7:0]          colour,
   output rleid_pkg::step_type step
);
   import rleid_pkg::*;

   localparam logic signed [11:0] SCREEN_W_S = 12'(SCREEN_W);
   localparam logic signed [11:0] SCREEN_H_S = 12'(SCREEN_H);

   typedef struct packed {
      logic       done;
      logic [9:0] x;
      logic [9:0] y;
   } settle_type;

   // wrap to the next row past the row end, flag completion past the last row or for an empty image
   function automatic settle_type settle(input logic [9:0] w, input logic [9:0] h,
                                         input logic [10:0] cx, input logic [10:0] cy);
      settle_type r;
      logic [10:0] x;
      logic [10:0] y;
      x = cx;
      y = cy;
      r.done = 1'b0;
      if (w == 10'd0 || h == 10'd0) begin
         r.done = 1'b1;
      end else begin
         if (x >= {1'b0, w}) begin
            x = 11'd0;
            y = y + 11'd1;
         end
         if (y >= {1'b0, h}) begin
            y = 11'd0;
            r.done = 1'b1;
         end
      end
      r.x = x[9:0];
      r.y = y[9:0];
      return r;
   endfunction

   settle_type        s1;
   settle_type        s2;
   logic signed [11:0] sx;
   logic signed [11:0] sy;
   logic              on_screen;

   always_comb begin
      s1 = settle(cfg.image_width, cfg.image_height, {1'b0, cursor_x}, {1'b0, cursor_y});
      sx = 12'($signed(cfg.origin_x)) + $signed({2'b00, s1.x});
      sy = 12'($signed(cfg.origin_y)) + $signed({2'b00, s1.y});
      on_screen = (sx >= 12'sd0) && (sx < SCREEN_W_S) && (sy >= 12'sd0) && (sy < SCREEN_H_S);
      s2 = settle(cfg.image_width, cfg.image_height, {1'b0, s1.x} + 11'd1, {1'b0, s1.y});

      step.first_done = s1.done;
      step.cur_x      = s1.x;
      step.cur_y      = s1.y;
      step.visible    = !s1.done && on_screen && (colour != cfg.see_through);
      step.pix_x      = sx[8:0];
      step.pix_y      = sy[7:0];
      step.next_done  = s2.done;
      step.next_x     = s2.x;
      step.next_y     = s2.y;
   end

endmodule

// ===== hw/rtl/rle_image_decoder_with_clipping_core.sv =====
// top level of the run-length image decoder with screen clipping
//
//   port      dir   handshake     carries
//   req       in    valid/ready   data_byte, stream_start, final_byte
//   rsp       out   valid/ready   pixel_x, pixel_y, pixel_colour, run_last
//   csr_*     in    write enable  register index and data, no read-back
//
// a byte that draws nothing (marker, ignored byte, zero count) is handled in IDLE alone
// a colour byte with run length n is accepted in IDLE, then takes up to n pixel steps in RUN,
// one per cycle in the shared step unit unless the result register stalls it, then a FLUSH of the held pixel;
// the run stops early once the image is full
// a visible pixel step waits while a pixel is held and the result register is full and not taken
// synchronous active-high reset; cursor and flags clear, registers read zero
module rle_image_decoder_with_clipping_core #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 200
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wen,
   input  rleid_pkg::csr_index_type                 csr_index,
   input  logic [rleid_pkg::CSR_DATA_W-1:0]         csr_wdata,
   rleid_req_if.sink                                req,
   rleid_rsp_if.source                              rsp
);
   import rleid_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      FLUSH
   } state_type;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_ORIGIN_X:    cfg_ff.origin_x     <= $signed(csr_wdata);
            CSR_ORIGIN_Y:    cfg_ff.origin_y     <= $signed(csr_wdata);
            CSR_IMAGE_W:     cfg_ff.image_width  <= csr_wdata[9:0];
            CSR_IMAGE_H:     cfg_ff.image_height <= csr_wdata[9:0];
            CSR_SEE_THROUGH: cfg_ff.see_through  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and decoder state
   state_type  state_ff, state_in;
   logic [9:0] cur_x_ff, cur_x_in;
   logic [9:0] cur_y_ff, cur_y_in;
   logic       done_ff, done_in;
   logic       mpend_ff, mpend_in;
   logic [5:0] pcount_ff, pcount_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [7:0] colour_ff, colour_in;
   logic       final_ff, final_in;

   // held pixel: waits until it is known whether it ends the byte's output
   logic       cand_valid_ff, cand_valid_in;
   logic [8:0] cand_x_ff, cand_x_in;
   logic [7:0] cand_y_ff, cand_y_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [8:0] out_x_ff, out_x_in;
   logic [7:0] out_y_ff, out_y_in;
   logic [7:0] out_colour_ff, out_colour_in;
   logic       out_last_ff, out_last_in;

   step_type   step;
   logic       out_free;

   // shared pixel step unit, one pixel of the run per cycle unless the result register stalls it
   rleid_pixel_step #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_step (
      .cfg      (cfg_ff),
      .cursor_x (cur_x_ff),
      .cursor_y (cur_y_ff),
      .colour   (colour_ff),
      .step     (step)
   );

   assign out_free = !out_valid_ff || rsp.ready;

   assign req.ready        = (state_ff == IDLE);
   assign rsp.valid        = out_valid_ff;
   assign rsp.pixel_x      = out_x_ff;
   assign rsp.pixel_y      = out_y_ff;
   assign rsp.pixel_colour = out_colour_ff;
   assign rsp.run_last     = out_last_ff;

   always_comb begin
      logic       eff_done;
      logic       eff_mpend;
      logic [5:0] eff_pcount;
      logic [5:0] count;

      state_in      = state_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      done_in       = done_ff;
      mpend_in      = mpend_ff;
      pcount_in     = pcount_ff;
      cnt_in        = cnt_ff;
      colour_in     = colour_ff;
      final_in      = final_ff;
      cand_valid_in = cand_valid_ff;
      cand_x_in     = cand_x_ff;
      cand_y_in     = cand_y_ff;
      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_colour_in = out_colour_ff;
      out_last_in   = out_last_ff;

      eff_done   = req.stream_start ? 1'b0 : done_ff;
      eff_mpend  = req.stream_start ? 1'b0 : mpend_ff;
      eff_pcount = req.stream_start ? 6'd0 : pcount_ff;
      count      = 6'd0;

      // taken result leaves the register
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req.valid) begin
               if (req.stream_start) begin
                  cur_x_in = 10'd0;
                  cur_y_in = 10'd0;
               end
               done_in   = eff_done;
               mpend_in  = eff_mpend;
               pcount_in = eff_pcount;
               if (eff_done) begin
                  // image complete: byte ignored
                  mpend_in = 1'b0;
               end else if (eff_mpend) begin
                  // colour byte after a marker
                  count     = eff_pcount;
                  mpend_in  = 1'b0;
                  pcount_in = 6'd0;
               end else if ((req.data_byte & MARKER_BITS) == MARKER_BITS) begin
                  mpend_in  = 1'b1;
                  pcount_in = 6'(req.data_byte & COUNT_MASK);
               end else begin
                  count = 6'd1;
               end

               if (count != 6'd0) begin
                  state_in  = RUN;
                  cnt_in    = count;
                  colour_in = req.data_byte;
                  final_in  = req.final_byte;
               end else if (req.final_byte && !eff_done) begin
                  // final byte drops any pending marker and ends the image
                  mpend_in  = 1'b0;
                  pcount_in = 6'd0;
                  done_in   = 1'b1;
               end
            end
         end

         RUN: begin
            if (step.first_done) begin
               // image already complete before this pixel
               done_in  = 1'b1;
               cur_x_in = step.cur_x;
               cur_y_in = step.cur_y;
               state_in = FLUSH;
            end else if (!(step.visible && cand_valid_ff && !out_free)) begin
               if (step.visible) begin
                  if (cand_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_x_in      = cand_x_ff;
                     out_y_in      = cand_y_ff;
                     out_colour_in = colour_ff;
                     out_last_in   = 1'b0;
                  end
                  cand_valid_in = 1'b1;
                  cand_x_in     = step.pix_x;
                  cand_y_in     = step.pix_y;
               end
               cur_x_in = step.next_x;
               cur_y_in = step.next_y;
               cnt_in   = cnt_ff - 6'd1;
               if (step.next_done) begin
                  done_in  = 1'b1;
                  state_in = FLUSH;
               end else if (cnt_ff == 6'd1) begin
                  state_in = FLUSH;
               end
            end
         end

         FLUSH: begin
            if (!cand_valid_ff || out_free) begin
               if (cand_valid_ff) begin
                  // last drawn pixel of the byte
                  out_valid_in  = 1'b1;
                  out_x_in      = cand_x_ff;
                  out_y_in      = cand_y_ff;
                  out_colour_in = colour_ff;
                  out_last_in   = 1'b1;
                  cand_valid_in = 1'b0;
               end
               if (final_ff) begin
                  mpend_in  = 1'b0;
                  pcount_in = 6'd0;
                  done_in   = 1'b1;
               end
               state_in = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         cur_x_ff      <= 10'd0;
         cur_y_ff      <= 10'd0;
         done_ff       <= 1'b0;
         mpend_ff      <= 1'b0;
         pcount_ff     <= 6'd0;
         cnt_ff        <= 6'd0;
         final_ff      <= 1'b0;
         cand_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         done_ff       <= done_in;
         mpend_ff      <= mpend_in;
         pcount_ff     <= pcount_in;
         cnt_ff        <= cnt_in;
         colour_ff     <= colour_in;
         final_ff      <= final_in;
         cand_valid_ff <= cand_valid_in;
         cand_x_ff     <= cand_x_in;
         cand_y_ff     <= cand_y_in;
         out_valid_ff  <= out_valid_in;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         out_colour_ff <= out_colour_in;
         out_last_ff   <= out_last_in;
      end
   end

   // no pixel may be left held once the byte is finished
   `RLEID_ASSERT_ALWAYS(a_idle_no_held_pixel, !(state_ff == IDLE && cand_valid_ff), "held pixel in idle")
   // a run in progress always has pixels left
   `RLEID_ASSERT_IMPLIES(a_run_count_nonzero, state_ff == RUN, cnt_ff != 6'd0, "run with zero count")
   // a run never starts on a finished image
   `RLEID_ASSERT_IMPLIES(a_run_not_done, state_ff == RUN, !done_ff, "run on finished image")
   // the flush leaves the held pixel in the result register
   `RLEID_ASSERT_NEXT(a_flush_marks_last, state_ff == FLUSH && cand_valid_ff && out_free, out_valid_ff && out_last_ff, "flush lost last pixel")

endmodule
